### design/quaternion_multiply_accumulate_assert.svh
// assertion macros shared by the quaternion multiply-accumulate modules
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef QUATERNION_MULTIPLY_ACCUMULATE_ASSERT_SVH
`define QUATERNION_MULTIPLY_ACCUMULATE_ASSERT_SVH

// expression holds at every rising clock edge out of reset
`define QMA_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define QMA_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequent holds in the cycle after the antecedent
`define QMA_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/qma_pkg.sv
// shared constants and types of the quaternion multiply-accumulate block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package qma_pkg;

  // default field format, Q1.14 in 16 bits
  localparam int unsigned DataWidthDef = 16;
  localparam int unsigned FracBitsDef  = 14;

  // entries in the queue between front and back
  localparam int unsigned QueueDepth = 2;

  // number of pre-added operand terms, two for each of the eight products
  localparam int unsigned NumTerms = 16;

  typedef enum logic {
    CMD_MUL = 1'b0,  // product replaces stored quaternion
    CMD_MAC = 1'b1   // product added to stored quaternion
  } qma_cmd_e;

endpackage

`default_nettype wire

### design/quaternion_multiply_accumulate.sv
// top level of the quaternion multiply-accumulate block: front, queue, back
// depends on qma_pkg, qma_front, qma_queue and qma_back
//
// usage:
//   slave channel s_axis carries one item per transfer: tdata holds the two
//   quaternions a and b, tuser the command (multiply, or multiply and add to
//   the stored quaternion). master channel m_axis returns one item for each
//   input item, in order: tdata holds the stored quaternion after the update,
//   tuser the saturation flag.
//   path: from acceptance to m_axis_tvalid an item passes the queue, the
//   multiplier stage, the recombine stage and the accumulate and output register.
//   throughput: one item per cycle while m_axis_tready is high, set by the
//   eight multipliers in one stage and the accumulate loop on the stored value.
//   reset: asynchronous, active low; clears the stored quaternion to zero and
//   empties the queue and every pipeline stage.
//   stall: a result waits in the output register while m_axis_tready is low;
//   the stages behind it keep filling and the two-entry queue takes further
//   items until it is full, then s_axis_tready drops.
`timescale 1ns / 1ps
`default_nettype none

module quaternion_multiply_accumulate #(
  parameter int unsigned DATA_WIDTH = qma_pkg::DataWidthDef,
  parameter int unsigned FRAC_BITS  = qma_pkg::FracBitsDef
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   s_axis_tvalid,
  output logic                                        s_axis_tready,
  // a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z from the lowest bit up
  input  wire logic [8*DATA_WIDTH-1:0]                s_axis_tdata,
  // cmd
  input  wire logic                                   s_axis_tuser,
  output logic                                        m_axis_tvalid,
  input  wire logic                                   m_axis_tready,
  // res_w, res_x, res_y, res_z from the lowest bit up, zero filled to bytes
  output logic [((4*DATA_WIDTH+7)/8)*8-1:0]           m_axis_tdata,
  // saturated
  output logic                                        m_axis_tuser
);
  import qma_pkg::*;

  localparam int unsigned EntW     = NumTerms * (DATA_WIDTH + 1) + 1;
  localparam int unsigned OutDataW = ((4 * DATA_WIDTH + 7) / 8) * 8;

  // front to queue
  logic            push_valid, push_ready;
  logic [EntW-1:0] push_data;
  // queue to back
  logic            op_valid, op_ready;
  logic [EntW-1:0] op_data;
  // back result
  logic [3:0][DATA_WIDTH-1:0] res_data;

  qma_front #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_front (
    .s_valid_i    (s_axis_tvalid),
    .s_ready_o    (s_axis_tready),
    .s_data_i     (s_axis_tdata),
    .s_cmd_i      (s_axis_tuser),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  // decouples operand intake from the multiplier pipeline
  qma_queue #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (op_valid),
    .pop_ready_i  (op_ready),
    .pop_data_o   (op_data)
  );

  qma_back #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_valid_i  (op_valid),
    .op_ready_o  (op_ready),
    .op_data_i   (op_data),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_data_o  (res_data),
    .res_sat_o   (m_axis_tuser)
  );

  // components packed w first, upper bits zero when not a whole byte
  assign m_axis_tdata = OutDataW'(res_data);

endmodule

`default_nettype wire

### design/qma_front.sv
// front end: takes input items, decodes the command and forms the pre-added
// operand pairs of the eight-multiplier product; depends on qma_pkg
`timescale 1ns / 1ps
`default_nettype none

module qma_front #(
  parameter int unsigned DATA_WIDTH = qma_pkg::DataWidthDef
) (
  input  wire logic                                         s_valid_i,
  output logic                                              s_ready_o,
  input  wire logic [8*DATA_WIDTH-1:0]                      s_data_i,
  input  wire logic                                         s_cmd_i,
  output logic                                              push_valid_o,
  input  wire logic                                         push_ready_i,
  output logic [qma_pkg::NumTerms*(DATA_WIDTH+1):0]         push_data_o
);
  import qma_pkg::*;

  localparam int unsigned W  = DATA_WIDTH;
  localparam int unsigned TW = DATA_WIDTH + 1;

  logic signed [W-1:0]  aw, ax, ay, az, bw, bx, by, bz;
  logic signed [TW-1:0] term [NumTerms];
  qma_cmd_e             cmd;

  assign aw = $signed(s_data_i[0*W +: W]);
  assign ax = $signed(s_data_i[1*W +: W]);
  assign ay = $signed(s_data_i[2*W +: W]);
  assign az = $signed(s_data_i[3*W +: W]);
  assign bw = $signed(s_data_i[4*W +: W]);
  assign bx = $signed(s_data_i[5*W +: W]);
  assign by = $signed(s_data_i[6*W +: W]);
  assign bz = $signed(s_data_i[7*W +: W]);

  assign cmd = s_cmd_i ? CMD_MAC : CMD_MUL;

  // even index left factor, odd index right factor, products A..H in order
  always_comb begin
    term[0]  = TW'(aw) + TW'(ax);
    term[1]  = TW'(bw) + TW'(bx);
    term[2]  = TW'(az) - TW'(ay);
    term[3]  = TW'(by) - TW'(bz);
    term[4]  = TW'(ax) - TW'(aw);
    term[5]  = TW'(by) + TW'(bz);
    term[6]  = TW'(ay) + TW'(az);
    term[7]  = TW'(bx) - TW'(bw);
    term[8]  = TW'(ax) + TW'(az);
    term[9]  = TW'(bx) + TW'(by);
    term[10] = TW'(ax) - TW'(az);
    term[11] = TW'(bx) - TW'(by);
    term[12] = TW'(aw) + TW'(ay);
    term[13] = TW'(bw) - TW'(bz);
    term[14] = TW'(aw) - TW'(ay);
    term[15] = TW'(bw) + TW'(bz);
  end

  always_comb begin
    push_data_o = '0;
    for (int k = 0; k < NumTerms; k++) begin
      push_data_o[k*TW +: TW] = term[k];
    end
    push_data_o[NumTerms*TW] = (cmd == CMD_MAC);
  end

  assign push_valid_o = s_valid_i;
  assign s_ready_o    = push_ready_i;

endmodule

`default_nettype wire

### design/qma_queue.sv
// short queue between front and back of the quaternion multiply-accumulate
// depends on qma_pkg and the assertion macro header
`timescale 1ns / 1ps
`default_nettype none

module qma_queue #(
  parameter int unsigned DATA_WIDTH = qma_pkg::DataWidthDef
) (
  input  wire logic                                         clk_i,
  input  wire logic                                         rst_ni,
  input  wire logic                                         push_valid_i,
  output logic                                              push_ready_o,
  input  wire logic [qma_pkg::NumTerms*(DATA_WIDTH+1):0]    push_data_i,
  output logic                                              pop_valid_o,
  input  wire logic                                         pop_ready_i,
  output logic [qma_pkg::NumTerms*(DATA_WIDTH+1):0]         pop_data_o
);
  import qma_pkg::*;

  `include "quaternion_multiply_accumulate_assert.svh"

  localparam int unsigned EntW = NumTerms * (DATA_WIDTH + 1) + 1;
  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  logic [EntW-1:0] mem_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            push, pop;

  assign push_ready_o = (cnt_q != CntW'(QueueDepth));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  `QMA_ASSERT_ALWAYS(a_cnt_bound, cnt_q <= CntW'(QueueDepth), "queue fill count over depth")
  `QMA_ASSERT_NXT(a_cnt_track, push && !pop, cnt_q == $past(cnt_q) + 1'b1, "push lost in queue")

endmodule

`default_nettype wire

### design/qma_back.sv
// back end: eight multipliers, recombination with halving and rescale, then
// accumulate, saturate and hold the result; depends on qma_pkg and macro header
`timescale 1ns / 1ps
`default_nettype none

module qma_back #(
  parameter int unsigned DATA_WIDTH = qma_pkg::DataWidthDef,
  parameter int unsigned FRAC_BITS  = qma_pkg::FracBitsDef
) (
  input  wire logic                                         clk_i,
  input  wire logic                                         rst_ni,
  input  wire logic                                         op_valid_i,
  output logic                                              op_ready_o,
  input  wire logic [qma_pkg::NumTerms*(DATA_WIDTH+1):0]    op_data_i,
  output logic                                              res_valid_o,
  input  wire logic                                         res_ready_i,
  output logic [3:0][DATA_WIDTH-1:0]                        res_data_o,
  output logic                                              res_sat_o
);
  import qma_pkg::*;

  `include "quaternion_multiply_accumulate_assert.svh"

  localparam int unsigned W    = DATA_WIDTH;
  localparam int unsigned TW   = DATA_WIDTH + 1;
  localparam int unsigned PW   = 2 * DATA_WIDTH + 2;
  localparam int unsigned SumW = 2 * DATA_WIDTH + 4;
  localparam int unsigned AccW = SumW + 1;

  localparam logic signed [AccW-1:0] SatMax = {{(AccW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [AccW-1:0] SatMin = {{(AccW-W+1){1'b1}}, {(W-1){1'b0}}};
  localparam logic [W-1:0] ResMax = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] ResMin = {1'b1, {(W-1){1'b0}}};

  logic                  mul_en, mix_en, out_en;
  logic                  mul_vld_q, mix_vld_q, out_vld_q;
  logic                  mul_mac_q, mix_mac_q;
  logic signed [PW-1:0]  prod_d [8];
  logic signed [PW-1:0]  prod_q [8];
  logic signed [SumW-1:0] ext [8];
  logic signed [SumW-1:0] mix_d [4];
  logic signed [SumW-1:0] mix_q [4];
  logic signed [AccW-1:0] tot [4];
  logic [3:0][W-1:0]     acc_d, acc_q;
  logic                  sat_d, sat_q;

  // stall chain, a stage takes new data when empty or when the next one moves
  assign out_en     = !out_vld_q || res_ready_i;
  assign mix_en     = !mix_vld_q || out_en;
  assign mul_en     = !mul_vld_q || mix_en;
  assign op_ready_o = mul_en;

  // stage one: eight independent multipliers
  always_comb begin
    for (int k = 0; k < 8; k++) begin
      prod_d[k] = PW'($signed(op_data_i[(2*k)*TW +: TW]) *
                      $signed(op_data_i[(2*k+1)*TW +: TW]));
    end
  end

  // stage two: recombine, halve and rescale by one floor shift
  always_comb begin
    for (int k = 0; k < 8; k++) begin
      ext[k] = SumW'(prod_q[k]);
    end
    mix_d[0] = ((ext[1] <<< 1) - ext[4] - ext[5] + ext[6] + ext[7]) >>> (FRAC_BITS + 1);
    mix_d[1] = ((ext[0] <<< 1) - ext[4] - ext[5] - ext[6] - ext[7]) >>> (FRAC_BITS + 1);
    mix_d[2] = (ext[4] + ext[6] - ext[5] - ext[7] - (ext[2] <<< 1)) >>> (FRAC_BITS + 1);
    mix_d[3] = (ext[4] + ext[7] - ext[5] - ext[6] - (ext[3] <<< 1)) >>> (FRAC_BITS + 1);
  end

  // stage three: accumulate at full precision and clip once
  always_comb begin
    sat_d = 1'b0;
    for (int c = 0; c < 4; c++) begin
      tot[c] = AccW'(mix_q[c]) + (mix_mac_q ? AccW'($signed(acc_q[c])) : '0);
      if (tot[c] > SatMax) begin
        acc_d[c] = ResMax;
        sat_d    = 1'b1;
      end else if (tot[c] < SatMin) begin
        acc_d[c] = ResMin;
        sat_d    = 1'b1;
      end else begin
        acc_d[c] = tot[c][W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_vld_q <= 1'b0;
      mix_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
      acc_q     <= '0;
      sat_q     <= 1'b0;
    end else begin
      if (mul_en) begin
        mul_vld_q <= op_valid_i;
      end
      if (mix_en) begin
        mix_vld_q <= mul_vld_q;
      end
      if (out_en) begin
        out_vld_q <= mix_vld_q;
        if (mix_vld_q) begin
          acc_q <= acc_d;
          sat_q <= sat_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mul_en) begin
      prod_q    <= prod_d;
      mul_mac_q <= op_data_i[NumTerms*TW];
    end
    if (mix_en) begin
      mix_q     <= mix_d;
      mix_mac_q <= mul_mac_q;
    end
  end

  assign res_valid_o = out_vld_q;
  assign res_data_o  = acc_q;
  assign res_sat_o   = sat_q;

  `QMA_ASSERT_NXT(a_acc_hold, out_vld_q && !res_ready_i, $stable(acc_q),
                  "stored quaternion changed under a stalled result")
  `QMA_ASSERT_IMP(a_sat_value, out_vld_q && sat_q,
                  acc_q[0] == ResMax || acc_q[0] == ResMin || acc_q[1] == ResMax ||
                  acc_q[1] == ResMin || acc_q[2] == ResMax || acc_q[2] == ResMin ||
                  acc_q[3] == ResMax || acc_q[3] == ResMin,
                  "saturated flag without a clipped component")

endmodule

`default_nettype wire

### sim/qma_checker.sv
// scoreboard for the quaternion multiply-accumulate block: predicts each result and compares
// depends on qma_pkg; watches both stream channels from the outside only
`timescale 1ns / 1ps

module qma_checker #(
  parameter int unsigned DW        = qma_pkg::DataWidthDef,
  parameter int unsigned FRAC_BITS = qma_pkg::FracBitsDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic                           in_ready_i,
  // a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z from the lowest bit up
  input  logic [8*DW-1:0]                in_data_i,
  // cmd
  input  logic                           in_cmd_i,
  input  logic                           out_valid_i,
  input  logic                           out_ready_i,
  // res_w, res_x, res_y, res_z from the lowest bit up
  input  logic [((4*DW+7)/8)*8-1:0]      out_data_i,
  // saturated
  input  logic                           out_sat_i,
  output int                             fail_count_o,
  output int                             pending_count_o
);

  localparam longint SatMax = (longint'(1) <<< (DW - 1)) - 1;
  localparam longint SatMin = -(longint'(1) <<< (DW - 1));

  typedef struct packed {
    logic                 sat;
    logic [3:0][DW-1:0]   part;  // w, x, y, z
  } quat_result_t;

  logic signed [DW-1:0] stored_quat [4];
  quat_result_t         expected_accs [$];
  quat_result_t         oldest_acc;
  quat_result_t         next_acc;
  string                part_names [4] = '{"res_w", "res_x", "res_y", "res_z"};

  task automatic flag_mismatch(input string what, input logic signed [63:0] got,
                               input logic signed [63:0] want);
    $display("%0t mismatch %0s: got %0d expected %0d", $realtime, what, got, want);
    fail_count_o++;
  endtask

  // hamilton product by the eight-multiplier factoring, floor rescale, then
  // optional add to the stored value and one saturation per component
  function automatic quat_result_t hamilton_update(input logic cmd,
                                                   input logic [8*DW-1:0] quats);
    longint       op [8];
    longint       pa, pb, pc, pd, pe, pf, pg, ph;
    longint       comp [4];
    longint       v;
    quat_result_t r;
    for (int k = 0; k < 8; k++) op[k] = longint'($signed(quats[k*DW +: DW]));
    // op: 0 aw, 1 ax, 2 ay, 3 az, 4 bw, 5 bx, 6 by, 7 bz
    pa = (op[0] + op[1]) * (op[4] + op[5]);
    pb = (op[3] - op[2]) * (op[6] - op[7]);
    pc = (op[1] - op[0]) * (op[6] + op[7]);
    pd = (op[2] + op[3]) * (op[5] - op[4]);
    pe = (op[1] + op[3]) * (op[5] + op[6]);
    pf = (op[1] - op[3]) * (op[5] - op[6]);
    pg = (op[0] + op[2]) * (op[4] - op[7]);
    ph = (op[0] - op[2]) * (op[4] + op[7]);
    // doubled so the halving and the rescale fold into one floor shift
    comp[0] = 2 * pb - pe - pf + pg + ph;
    comp[1] = 2 * pa - (pe + pf + pg + ph);
    comp[2] = -2 * pc + pe - pf + pg - ph;
    comp[3] = -2 * pd + pe - pf - pg + ph;
    r.sat = 1'b0;
    for (int i = 0; i < 4; i++) begin
      v = comp[i] >>> (FRAC_BITS + 1);
      if (cmd == qma_pkg::CMD_MAC) v = v + longint'(stored_quat[i]);
      if (v > SatMax) begin
        v = SatMax;
        r.sat = 1'b1;
      end else if (v < SatMin) begin
        v = SatMin;
        r.sat = 1'b1;
      end
      r.part[i] = v[DW-1:0];
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) stored_quat[i] = '0;
      expected_accs.delete();
      fail_count_o    = 0;
      pending_count_o = 0;
    end else begin
      // results first: one accepted in this cycle always belongs to an older item
      if (out_valid_i && out_ready_i) begin
        if (expected_accs.size() == 0) begin
          flag_mismatch("result with nothing outstanding", $signed(out_data_i[DW-1:0]), 0);
        end else begin
          oldest_acc = expected_accs.pop_front();
          for (int i = 0; i < 4; i++) begin
            if (out_data_i[i*DW +: DW] !== oldest_acc.part[i])
              flag_mismatch(part_names[i], $signed(out_data_i[i*DW +: DW]),
                            $signed(oldest_acc.part[i]));
          end
          if (out_sat_i !== oldest_acc.sat)
            flag_mismatch("saturated", {63'd0, out_sat_i}, {63'd0, oldest_acc.sat});
        end
      end
      if (in_valid_i && in_ready_i) begin
        next_acc = hamilton_update(in_cmd_i, in_data_i);
        for (int i = 0; i < 4; i++) stored_quat[i] = next_acc.part[i];
        expected_accs.push_back(next_acc);
      end
      pending_count_o = expected_accs.size();
    end
  end

endmodule

### sim/tb_quaternion_multiply_accumulate.sv
// top of the regression for the quaternion multiply-accumulate block: clock, reset, stimulus
// depends on qma_pkg, quaternion_multiply_accumulate and qma_checker
`timescale 1ns / 1ps

module tb_quaternion_multiply_accumulate;

  import qma_pkg::*;

  localparam int unsigned DW            = DataWidthDef;
  localparam int unsigned OutW          = ((4 * DW + 7) / 8) * 8;
  localparam int          RandomItems   = 700;
  localparam int          CalmTail      = 120;   // final items with no idling at all
  localparam int          HoldAt        = 40;    // random item at which the long hold starts
  localparam int          HoldCycles    = 60;    // long receiver hold-off
  localparam int          WatchdogLimit = 2000;  // cycles with no item moving either way
  localparam int          DrainCycles   = 8;     // extra wait after the last expected result

  localparam logic [DW-1:0] QOne = 16'sd16384;  // 1.0 in Q1.14
  localparam logic [DW-1:0] QMax = 16'h7fff;
  localparam logic [DW-1:0] QMin = 16'h8000;
  localparam logic [DW-1:0] QZero = '0;

  logic             clk_i;
  logic             rst_ni;
  logic             s_axis_tvalid;
  logic             s_axis_tready;
  // a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z from the lowest bit up
  logic [8*DW-1:0]  s_axis_tdata;
  // cmd
  logic             s_axis_tuser;
  logic             m_axis_tvalid;
  logic             m_axis_tready;
  // res_w, res_x, res_y, res_z from the lowest bit up
  logic [OutW-1:0]  m_axis_tdata;
  // saturated
  logic             m_axis_tuser;

  int               fail_count;
  int               pending_count;

  // idling controls for the sender and the receiver
  bit               sender_gaps;
  bit               sink_stalls;
  bit               hold_trigger;

  // random stimulus scratch
  qma_cmd_e         rand_cmd;
  logic [8*DW-1:0]  rand_quats;
  int               chain_left;
  int               value_mode;
  int               part_val;

  quaternion_multiply_accumulate dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // scoreboard sits beside the block and only watches the two channels
  qma_checker #(
    .DW        (DW),
    .FRAC_BITS (FracBitsDef)
  ) scoreboard (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (s_axis_tvalid),
    .in_ready_i      (s_axis_tready),
    .in_data_i       (s_axis_tdata),
    .in_cmd_i        (s_axis_tuser),
    .out_valid_i     (m_axis_tvalid),
    .out_ready_i     (m_axis_tready),
    .out_data_i      (m_axis_tdata),
    .out_sat_i       (m_axis_tuser),
    .fail_count_o    (fail_count),
    .pending_count_o (pending_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // packs a and b in tdata order, w of a in the lowest bits
  function automatic logic [8*DW-1:0] quat_pair(
    input logic [DW-1:0] aw, input logic [DW-1:0] ax,
    input logic [DW-1:0] ay, input logic [DW-1:0] az,
    input logic [DW-1:0] bw, input logic [DW-1:0] bx,
    input logic [DW-1:0] by, input logic [DW-1:0] bz);
    return {bz, by, bx, bw, az, ay, ax, aw};
  endfunction

  // offers one item from the falling edge on and returns at the accepting rising edge;
  // valid stays high into the next call, which drops it only for a random gap while sender_gaps is set
  task automatic send_quats(input qma_cmd_e cmd, input logic [8*DW-1:0] quats);
    @(negedge clk_i);
    if (sender_gaps && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= quats;
    s_axis_tuser  <= cmd;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // receiver: random stall bursts, quiet stretches, and one long hold-off that
  // lets the pipeline and queue fill until the input side stalls
  initial begin
    int hold_left;
    int stall_left;
    int sink_cycle;
    hold_left  = 0;
    stall_left = 0;
    sink_cycle = 0;
    forever begin
      @(negedge clk_i);
      sink_cycle++;
      if (hold_trigger) begin
        hold_trigger = 1'b0;
        hold_left    = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (sink_stalls && (sink_cycle % 97) < 70 && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(1, 6) - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // watchdog: ends the run when no item moves on either channel for too long
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WatchdogLimit) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = CMD_MUL;
    m_axis_tready = 1'b0;
    sender_gaps   = 1'b1;
    sink_stalls   = 1'b1;
    hold_trigger  = 1'b0;
    chain_left    = 0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: identities, unit axes, extremes, floor rounding, accumulate and clipping
    send_quats(CMD_MUL, quat_pair(QZero, QZero, QZero, QZero, QZero, QZero, QZero, QZero));
    send_quats(CMD_MUL, quat_pair(QOne, QZero, QZero, QZero,
                                  16'sd1234, -16'sd2345, 16'sd3456, -16'sd4567));
    // i times j gives k
    send_quats(CMD_MUL, quat_pair(QZero, QOne, QZero, QZero, QZero, QZero, QOne, QZero));
    // j times i gives minus k
    send_quats(CMD_MUL, quat_pair(QZero, QZero, QOne, QZero, QZero, QOne, QZero, QZero));
    send_quats(CMD_MUL, quat_pair(QMax, QMax, QMax, QMax, QMax, QMax, QMax, QMax));
    send_quats(CMD_MUL, quat_pair(QMin, QMin, QMin, QMin, QMin, QMin, QMin, QMin));
    send_quats(CMD_MUL, quat_pair(QMax, QMax, QMax, QMax, QMin, QMin, QMin, QMin));
    send_quats(CMD_MUL, quat_pair(QMax, QMin, QMax, QMin, QMin, QMax, QMin, QMax));
    // tiny negative product rounds down to minus one lsb, tiny positive to zero
    send_quats(CMD_MUL, quat_pair(-16'sd1, QZero, QZero, QZero, 16'sd1, QZero, QZero, QZero));
    send_quats(CMD_MUL, quat_pair(16'sd1, QZero, QZero, QZero, 16'sd1, QZero, QZero, QZero));
    // accumulate chain that clips high and low, then adds at full precision to the clip
    send_quats(CMD_MUL, quat_pair(QOne, QZero, QZero, QZero,
                                  16'sd16000, 16'sd16000, -16'sd16000, -16'sd16000));
    send_quats(CMD_MAC, quat_pair(QOne, QZero, QZero, QZero,
                                  16'sd16000, 16'sd16000, -16'sd16000, -16'sd16000));
    send_quats(CMD_MAC, quat_pair(QOne, QZero, QZero, QZero,
                                  16'sd16000, 16'sd16000, -16'sd16000, -16'sd16000));
    send_quats(CMD_MAC, quat_pair(QOne, QZero, QZero, QZero, QMin, QMin, QMax, QMax));
    // zero product leaves the stored quaternion as it is
    send_quats(CMD_MAC, quat_pair(QZero, QZero, QZero, QZero, QZero, QZero, QZero, QZero));
    // stored at the negative limit, then one lsb further down
    send_quats(CMD_MUL, quat_pair(QOne, QZero, QZero, QZero, QMin, QMin, QMin, QMin));
    send_quats(CMD_MAC, quat_pair(-16'sd1, QZero, QZero, QZero,
                                  16'sd1, 16'sd1, 16'sd1, 16'sd1));
    send_quats(CMD_MAC, quat_pair(QMin, QMax, QMin, QMax, QMax, QMin, QMax, QMin));
    send_quats(CMD_MUL, quat_pair(QMax, QMax, QMax, QMax, QMax, QZero, QZero, QZero));
    send_quats(CMD_MAC, quat_pair(QMin, QZero, QZero, QZero, QMax, QMax, QMax, QMax));

    // random: multiply then a run of multiply-adds, with mixed value ranges
    for (int n = 0; n < RandomItems; n++) begin
      if (n == HoldAt) hold_trigger = 1'b1;
      sender_gaps = (n < RandomItems - CalmTail) && ((n % 80) < 60);
      sink_stalls = (n < RandomItems - CalmTail);
      if (chain_left == 0) begin
        rand_cmd   = CMD_MUL;
        chain_left = $urandom_range(0, 8);
      end else begin
        rand_cmd = CMD_MAC;
        chain_left--;
      end
      if ($urandom_range(0, 7) == 0) rand_cmd = qma_cmd_e'($urandom_range(0, 1));
      // full range saturates often, moderate and tiny values stay in range
      value_mode = $urandom_range(0, 9);
      for (int k = 0; k < 8; k++) begin
        if (value_mode < 3)
          part_val = $urandom_range(0, 65535);
        else if (value_mode < 8)
          part_val = $urandom_range(0, 24000) - 12000;
        else if ($urandom_range(0, 7) == 0)
          part_val = $urandom_range(0, 1) ? 32767 : -32768;
        else
          part_val = $urandom_range(0, 600) - 300;
        rand_quats[k*DW +: DW] = part_val[DW-1:0];
      end
      send_quats(rand_cmd, rand_quats);
    end

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    // drain: the watchdog covers a result that never comes
    while (pending_count != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0 && pending_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
